// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the channel allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define PTCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, but also active while reset is asserted.
`define PTCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ptca_pkg.sv =====
// ----------------------------------------------------------------------------
// ptca_pkg
// Shared widths, operation codes and types of the paired timer channel
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptca_pkg;

  localparam int unsigned FREQ_W = 26;
  localparam int unsigned CHAN_W = 4;

  // operation codes carried by func_i
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // scan outcome, valid for one cycle when done is set
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ptca_ram.sv =====
// ----------------------------------------------------------------------------
// ptca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ptca_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/ptca_scan.sv =====
// ----------------------------------------------------------------------------
// ptca_scan
// Channel scan sequencer: walks the channels one per cycle, reads the pair
// partner's stored frequency and runs it through one shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module ptca_scan
  import ptca_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            go_i,
  input  wire logic [NUM_CHANNELS-1:0]         used_i,
  input  wire logic [FREQ_W-1:0]               freq_i,
  output logic      [$clog2(NUM_CHANNELS)-1:0] rd_addr_o,
  input  wire logic [FREQ_W-1:0]               rd_data_i,
  output scan_stat_t                           stat_o,
  output logic      [$clog2(NUM_CHANNELS)-1:0] chan_o
);

  localparam int unsigned CW = $clog2(NUM_CHANNELS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic          state_q, state_d;
  logic [CW:0]   iss_q, iss_d;       // channel whose partner is being read
  logic          cmp_vld_q, cmp_vld_d;
  logic [CW-1:0] cmp_ch_q, cmp_ch_d; // channel under compare

  logic          iss_in;
  logic [CW-1:0] iss_partner;
  logic          iss_p_in;
  logic [CW-1:0] partner;
  logic          p_in;
  logic          p_used;
  logic          own_used;
  logic          hit;
  logic          last;

  // read stage: fetch partner frequency, stay in range for the odd tail
  always_comb begin
    iss_in      = iss_q < (CW+1)'(NUM_CHANNELS);
    iss_partner = iss_q[CW-1:0] ^ CW'(1);
    iss_p_in    = {1'b0, iss_partner} < (CW+1)'(NUM_CHANNELS);
    rd_addr_o   = iss_p_in ? iss_partner : iss_q[CW-1:0];
  end

  // compare stage: shared frequency comparator
  always_comb begin
    partner  = cmp_ch_q ^ CW'(1);
    p_in     = {1'b0, partner} < (CW+1)'(NUM_CHANNELS);
    p_used   = p_in ? used_i[partner] : 1'b0;
    own_used = used_i[cmp_ch_q];
    hit      = cmp_vld_q && !own_used && (!p_used || (rd_data_i == freq_i));
    last     = cmp_vld_q && (cmp_ch_q == CW'(NUM_CHANNELS - 1));
  end

  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    cmp_vld_d    = 1'b0;
    cmp_ch_d     = cmp_ch_q;
    stat_o.done  = 1'b0;
    stat_o.found = 1'b0;
    chan_o       = cmp_ch_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_SCAN;
          iss_d   = '0;
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          stat_o.done  = 1'b1;
          stat_o.found = hit;
          state_d      = S_IDLE;
        end else if (iss_in) begin
          cmp_vld_d = 1'b1;
          cmp_ch_d  = iss_q[CW-1:0];
          iss_d     = iss_q + (CW+1)'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_ch_q <= cmp_ch_d;
  end

endmodule

`default_nettype wire

// ===== hdl/paired_timer_channel_allocator_top.sv =====
// ----------------------------------------------------------------------------
// paired_timer_channel_allocator_top
// First-fit allocator of PWM channels whose even/odd pairs share one timer.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  command   | start / busy       | func_i, frequency_i, release_channel_i
//  result    | valid_o (strobe)   | granted_channel_o, success_o
//
//  A release word is answered in the cycle after it is taken; busy stays low.
//  An allocate word raises busy while the scan walks one channel per cycle
//  through the frequency RAM and its single comparator. It stops at the first
//  channel that fits, or fails after the last one, and the result is registered.
//  The RAM's registered read port sets the pace of the scan.
//  Reset (rst_ni low, asynchronous) frees every channel; stored frequencies
//  are not cleared and need no clearing pass. The result strobe lasts one
//  cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module paired_timer_channel_allocator_top
  import ptca_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func_i,
  input  wire logic [FREQ_W-1:0] frequency_i,
  input  wire logic [CHAN_W-1:0] release_channel_i,
  output logic                   valid_o,
  output logic      [CHAN_W-1:0] granted_channel_o,
  output logic                   success_o
);

  localparam int unsigned CW = $clog2(NUM_CHANNELS);
  // widths big enough for both a channel number and the 4-bit fields
  localparam int unsigned RW = (CW > CHAN_W) ? CW : CHAN_W;

  localparam logic T_IDLE  = 1'b0;
  localparam logic T_ALLOC = 1'b1;

  logic                    state_q, state_d;
  logic [NUM_CHANNELS-1:0] used_q, used_d;
  logic [FREQ_W-1:0]       freq_q;
  logic                    valid_q, valid_d;
  logic [CHAN_W-1:0]       gch_q, gch_d;
  logic                    succ_q, succ_d;

  logic                    accept;
  logic                    rel_in;
  logic [RW-1:0]           rel_ext;
  logic [RW-1:0]           grant_ext;

  logic [CW-1:0]           rd_addr;
  logic [FREQ_W-1:0]       rd_data;
  scan_stat_t              scan_stat;
  logic [CW-1:0]           scan_chan;
  logic                    ram_we;

  assign busy   = (state_q != T_IDLE);
  assign accept = start && !busy;

  // release target: range check and index into the used mask
  assign rel_in    = 32'(release_channel_i) < 32'(NUM_CHANNELS);
  assign rel_ext   = RW'(release_channel_i);
  assign grant_ext = RW'(scan_chan);

  // store the frequency of a granted channel
  assign ram_we = scan_stat.done && scan_stat.found;

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    valid_d = 1'b0;
    gch_d   = '0;
    succ_d  = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_RELEASE) begin
            // answer at once: drop the used mark when the channel exists
            valid_d = 1'b1;
            succ_d  = rel_in;
            if (rel_in) begin
              used_d[rel_ext[CW-1:0]] = 1'b0;
            end
          end else begin
            state_d = T_ALLOC;
          end
        end
      end
      T_ALLOC: begin
        if (scan_stat.done) begin
          valid_d = 1'b1;
          succ_d  = scan_stat.found;
          state_d = T_IDLE;
          if (scan_stat.found) begin
            gch_d             = grant_ext[CHAN_W-1:0];
            used_d[scan_chan] = 1'b1;
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      used_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      valid_q <= valid_d;
    end
  end

  // hold the request frequency for the whole scan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      freq_q <= frequency_i;
    end
    gch_q  <= gch_d;
    succ_q <= succ_d;
  end

  assign valid_o           = valid_q;
  assign granted_channel_o = gch_q;
  assign success_o         = succ_q;

  ptca_scan #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept && (func_i == FUNC_ALLOC)),
    .used_i    (used_q),
    .freq_i    (freq_q),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .stat_o    (scan_stat),
    .chan_o    (scan_chan)
  );

  ptca_ram #(
    .WIDTH (FREQ_W),
    .DEPTH (NUM_CHANNELS)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (scan_chan),
    .wdata_i (freq_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

endmodule

`default_nettype wire

// ===== hdl/ptca_checker.sv =====
// ----------------------------------------------------------------------------
// ptca_checker
// Port-level checks of the channel allocator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptca_checker
  import ptca_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              func_i,
  input wire logic              valid_o,
  input wire logic [CHAN_W-1:0] granted_channel_o,
  input wire logic              success_o
);

  `PTCA_ASSERT(a_release_answers, start && !busy && (func_i == FUNC_RELEASE) |=> valid_o && !busy, "release word not answered in the next cycle")
  `PTCA_ASSERT(a_alloc_busy, start && !busy && (func_i == FUNC_ALLOC) |=> busy && !valid_o, "allocate word did not start a scan")
  `PTCA_ASSERT(a_scan_end_result, $fell(busy) |-> valid_o, "scan ended without a result")
  `PTCA_ASSERT(a_fail_zero, valid_o && !success_o |-> (granted_channel_o == '0), "failed result carries a channel")
  `PTCA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !busy && !valid_o, "block not idle after reset")

endmodule

bind paired_timer_channel_allocator_top ptca_checker u_ptca_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the paired timer channel allocator. A driver feeds
// allocate and release words from a pending queue through the start/busy
// handshake and predicts each grant as the word is taken. A monitor compares
// every result strobe with the oldest predicted grant, field by field.
// ----------------------------------------------------------------------------

module testbench;
  import ptca_pkg::*;

  localparam int unsigned NCH              = 16;
  localparam int unsigned RANDOM_WORDS     = 1930;
  // the last words of the run go out back to back
  localparam int unsigned QUIET_TAIL_WORDS = 250;
  // well above the length of a failing scan plus the widest gap
  localparam int unsigned WATCHDOG_LIMIT   = 1000;
  localparam int unsigned TAIL_CYCLES      = NCH + 8;
  localparam int unsigned DRAIN_EVERY      = 400;

  // one command word plus the pacing that goes with it
  typedef struct {
    logic              func;
    logic [FREQ_W-1:0] freq;
    logic [CHAN_W-1:0] rel;
    int unsigned       gap;    // idle cycles in front of this word
    bit                drain;  // hold this word until every grant is back
  } cmd_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              ok;
  } grant_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic              clk_i             = 1'b0;
  logic              rst_ni            = 1'b0;
  logic              start             = 1'b0;
  logic              busy;
  logic              func_i            = FUNC_ALLOC;
  logic [FREQ_W-1:0] frequency_i       = '0;
  logic [CHAN_W-1:0] release_channel_i = '0;
  logic              valid_o;
  logic [CHAN_W-1:0] granted_channel_o;
  logic              success_o;

  always #5 clk_i = ~clk_i;

  paired_timer_channel_allocator_top #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .frequency_i      (frequency_i),
    .release_channel_i(release_channel_i),
    .valid_o          (valid_o),
    .granted_channel_o(granted_channel_o),
    .success_o        (success_o)
  );

  // --------------------------------------------------------------------------
  // Channel map shadow: one used bit and one stored frequency per channel.
  // --------------------------------------------------------------------------
  logic [NCH-1:0]    chan_taken = '0;
  logic [FREQ_W-1:0] chan_freq [NCH];

  cmd_word_t   pending_words[$];
  grant_t      grant_queue[$];
  cmd_word_t   cur_word;
  bit          word_held   = 1'b0;
  int unsigned idle_left   = 0;
  int unsigned words_taken = 0;
  int unsigned total_words = 0;
  int unsigned mismatches  = 0;
  int unsigned quiet_cycles = 0;
  grant_t      oldest_grant;

  // Frequencies of the current random episode; a small pool makes pair
  // partners meet at the same frequency often.
  logic [FREQ_W-1:0] freq_pool [4];
  int unsigned       pool_n;

  // Apply one word to the shadow map and return the grant it causes.
  // Allocate takes the lowest free channel whose partner is free or runs at
  // the same frequency; when none fits, nothing changes and ok stays low.
  function automatic grant_t apply_word(cmd_word_t w);
    grant_t      g;
    int unsigned ch;
    int unsigned partner;
    bit          blocked;
    g = '0;
    if (w.func == FUNC_RELEASE) begin
      if (w.rel < NCH) begin
        chan_taken[w.rel] = 1'b0;
        g.ok = 1'b1;
      end
    end else begin
      for (ch = 0; ch < NCH && !g.ok; ch++) begin
        partner = ch ^ 1;
        blocked = chan_taken[ch] ||
                  (partner < NCH && chan_taken[partner] && chan_freq[partner] != w.freq);
        if (!blocked) begin
          chan_taken[ch] = 1'b1;
          chan_freq[ch]  = w.freq;
          g.channel      = ch[CHAN_W-1:0];
          g.ok           = 1'b1;
        end
      end
    end
    return g;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    // mostly pool values, now and then any 26-bit value
    if ($urandom_range(0, 9) == 0)
      return FREQ_W'($urandom());
    return freq_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  task automatic queue_word(logic func, logic [FREQ_W-1:0] freq, logic [CHAN_W-1:0] rel,
                            int unsigned gap, bit drain);
    cmd_word_t w;
    w.func  = func;
    w.freq  = freq;
    w.rel   = rel;
    w.gap   = gap;
    w.drain = drain;
    pending_words.push_back(w);
    total_words++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present words from the pending queue and hold each one until the
  // block takes it. Predict the grant at the edge that takes the word.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      word_held = 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        grant_queue.push_back(apply_word(cur_word));
        words_taken++;
        word_held = 1'b0;
        idle_left = (pending_words.size() > 0) ? pending_words[0].gap : 0;
      end
      if (!word_held) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].drain && grant_queue.size() != 0)) begin
          cur_word  = pending_words.pop_front();
          word_held = 1'b1;
        end
      end
      // one assignment per signal per edge: start stays high across
      // back-to-back words
      start <= word_held;
      if (word_held) begin
        func_i            <= cur_word.func;
        frequency_i       <= cur_word.freq;
        release_channel_i <= cur_word.rel;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take every result strobe and check it against the oldest grant.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && valid_o !== 1'b0) begin
      if (grant_queue.size() == 0) begin
        $error("result word with no grant pending: granted_channel %0d success %0b",
               granted_channel_o, success_o);
        mismatches++;
      end else begin
        oldest_grant = grant_queue.pop_front();
        if (granted_channel_o !== oldest_grant.channel) begin
          $error("granted_channel: expected %0d, actual %0d",
                 oldest_grant.channel, granted_channel_o);
          mismatches++;
        end
        if (success_o !== oldest_grant.ok) begin
          $error("success: expected %0b, actual %0b", oldest_grant.ok, success_o);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles in which neither a command nor a result moves.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o === 1'b1)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned i;
    int unsigned ep_len;
    int unsigned alloc_pct;
    int unsigned gap;
    bit          gaps_on;
    bit          quiet;
    bit          drain;

    for (i = 0; i < NCH; i++)
      chan_freq[i] = '0;

    // Directed part: extreme frequencies, pair sharing and mismatch, release
    // of a free channel, a full map that turns an allocate away.
    queue_word(FUNC_ALLOC,   26'd1,        4'd0,  0, 1'b0);  // channel 0
    queue_word(FUNC_ALLOC,   26'd40000000, 4'd15, 0, 1'b0);  // partner mismatch, channel 2
    queue_word(FUNC_ALLOC,   26'd1,        4'd0,  1, 1'b0);  // same frequency, channel 1
    queue_word(FUNC_ALLOC,   26'd0,        4'd0,  0, 1'b0);  // below range, stored as is
    queue_word(FUNC_ALLOC,   '1,           4'd0,  2, 1'b0);  // all ones
    queue_word(FUNC_RELEASE, 26'd0,        4'd0,  0, 1'b0);
    queue_word(FUNC_RELEASE, '1,           4'd0,  0, 1'b0);  // already free
    queue_word(FUNC_ALLOC,   26'd1,        4'd0,  0, 1'b0);  // back into channel 0
    queue_word(FUNC_RELEASE, 26'd0,        4'd15, 3, 1'b0);  // highest, free
    for (i = 0; i < 9; i++)
      queue_word(FUNC_ALLOC, 26'd5, 4'(i), 0, 1'b0);         // fill, last one fails
    queue_word(FUNC_ALLOC,   26'd40000000, 4'd0,  0, 1'b0);  // join channel 2
    queue_word(FUNC_ALLOC,   26'd7,        4'd0,  0, 1'b0);  // no channel fits
    queue_word(FUNC_ALLOC,   26'd0,        4'd0,  0, 1'b0);
    queue_word(FUNC_ALLOC,   '1,           4'd0,  0, 1'b0);
    queue_word(FUNC_RELEASE, 26'd0,        4'd8,  0, 1'b0);
    queue_word(FUNC_RELEASE, 26'd0,        4'd3,  0, 1'b0);

    // Random part: episodes that lean toward filling or emptying the map,
    // each with its own small frequency pool.
    n = 0;
    while (n < RANDOM_WORDS) begin
      ep_len  = $urandom_range(20, 60);
      pool_n  = $urandom_range(1, 4);
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 90;
        1:       alloc_pct = 60;
        default: alloc_pct = 30;
      endcase
      for (i = 0; i < pool_n; i++) begin
        case ($urandom_range(0, 5))
          0:       freq_pool[i] = 26'd1;
          1:       freq_pool[i] = 26'd40000000;
          2:       freq_pool[i] = 26'd0;
          3:       freq_pool[i] = '1;
          4:       freq_pool[i] = FREQ_W'($urandom());
          default: freq_pool[i] = FREQ_W'($urandom_range(1, 40000000));
        endcase
      end
      for (i = 0; i < ep_len && n < RANDOM_WORDS; i++) begin
        quiet = (n >= RANDOM_WORDS - QUIET_TAIL_WORDS);
        gap   = (!quiet && gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        drain = (n % DRAIN_EVERY == 0);
        if ($urandom_range(0, 99) < alloc_pct)
          queue_word(FUNC_ALLOC, pick_freq(), CHAN_W'($urandom()), gap, drain);
        else
          queue_word(FUNC_RELEASE, FREQ_W'($urandom()), CHAN_W'($urandom()), gap, drain);
        n++;
      end
    end

    // Hold reset, then release it on a falling edge, away from the sampling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every word to be taken and every grant to come back, then
    // let the block settle before the verdict.
    while (words_taken != total_words || grant_queue.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ptca_pkg.sv
hdl/ptca_ram.sv
hdl/ptca_scan.sv
hdl/paired_timer_channel_allocator_top.sv
hdl/ptca_checker.sv
sim/testbench.sv
